[rtl/kscan_pkg.sv]
// ----------------------------------------------------------------------------
// kscan_pkg
// Shared types and constants for the keypad scanner and digit queue.
// ----------------------------------------------------------------------------
package kscan_pkg;

  // Digit writes per tick and field widths of a result
  localparam int unsigned DIGITS     = 8;
  localparam int unsigned DIGIT_W    = 3;
  localparam int unsigned KEY_W      = 4;
  localparam int unsigned ROW_OUT_W  = 2;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned LAST_KEY_W = 8;
  // Decoded key width before range check (row*4 + 4, rows up to 8)
  localparam int unsigned RAW_KEY_W  = 6;

  // Last-key marker for a row with nothing pressed
  localparam logic [LAST_KEY_W-1:0] NO_KEY = 8'hFF;

  // Column codes that identify a single key in a row
  localparam logic [COL_W-1:0] COL_KEY1 = 8'h08;
  localparam logic [COL_W-1:0] COL_KEY2 = 8'h04;
  localparam logic [COL_W-1:0] COL_KEY3 = 8'h02;
  localparam logic [COL_W-1:0] COL_KEY4 = 8'h01;

  // Key code that wraps back to zero, and first code that is not queued
  localparam logic [RAW_KEY_W-1:0] KEY_WRAP  = 6'd16;
  localparam logic [RAW_KEY_W-1:0] KEY_LIMIT = 6'd16;

  // Command from the classifier to the display side
  typedef struct packed {
    logic                 flip;      // switch edge: toggle direction, blank ring
    logic                 wr;        // append key to the ring
    logic [KEY_W-1:0]     key;
    logic [ROW_OUT_W-1:0] next_row;
  } kscan_cmd_t;

endpackage

[rtl/kscan_front.sv]
// ----------------------------------------------------------------------------
// kscan_front
// Accepts scan ticks, tracks the switch and the scanned row, decodes keys
// and turns each tick into one command for the display side.
// ----------------------------------------------------------------------------
module kscan_front #(
  parameter int KEY_ROWS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            switch_pressed,
  input  logic [kscan_pkg::COL_W-1:0]     column_bits,
  output logic                            cmd_push,
  input  logic                            cmd_full,
  output kscan_pkg::kscan_cmd_t           cmd
);
  import kscan_pkg::*;

  localparam int RW = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;

  logic                  switch_held;
  logic [RW-1:0]         scan_row;
  logic [RW-1:0]         scan_row_next;
  logic [LAST_KEY_W-1:0] row_last_key [KEY_ROWS];

  logic                  hit;
  logic [2:0]            key_col;
  logic [RAW_KEY_W-1:0]  key_raw;
  logic [RAW_KEY_W-1:0]  key_dec;
  logic [LAST_KEY_W-1:0] last_key_next;
  logic                  accept;

  assign in_stall = cmd_full;
  assign accept   = in_valid && !cmd_full;
  assign cmd_push = accept;

  // Column code to key column
  always_comb begin
    hit     = 1'b1;
    key_col = 3'd0;
    case (column_bits)
      COL_KEY1: key_col = 3'd1;
      COL_KEY2: key_col = 3'd2;
      COL_KEY3: key_col = 3'd3;
      COL_KEY4: key_col = 3'd4;
      default:  hit     = 1'b0;
    endcase
  end

  // Key code, with the wrap of 16 to 0
  always_comb begin
    key_raw       = RAW_KEY_W'({scan_row, 2'b00}) + RAW_KEY_W'(key_col);
    key_dec       = (key_raw == KEY_WRAP) ? '0 : key_raw;
    last_key_next = hit ? LAST_KEY_W'(key_dec) : NO_KEY;
    scan_row_next = (scan_row == RW'(KEY_ROWS - 1)) ? '0 : scan_row + 1'b1;
  end

  // Command for this tick
  always_comb begin
    cmd.flip     = switch_pressed && !switch_held;
    cmd.wr       = hit && (key_dec < KEY_LIMIT) &&
                   (LAST_KEY_W'(key_dec) != row_last_key[scan_row]);
    cmd.key      = key_dec[KEY_W-1:0];
    cmd.next_row = ROW_OUT_W'(scan_row_next);
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_held <= 1'b0;
      scan_row    <= '0;
      for (int r = 0; r < KEY_ROWS; r++) begin
        row_last_key[r] <= NO_KEY;
      end
    end else if (accept) begin
      switch_held            <= switch_pressed;
      scan_row               <= scan_row_next;
      row_last_key[scan_row] <= last_key_next;
    end
  end

endmodule

[rtl/kscan_queue.sv]
// ----------------------------------------------------------------------------
// kscan_queue
// Two-entry command queue between the classifier and the display side.
// ----------------------------------------------------------------------------
module kscan_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  kscan_pkg::kscan_cmd_t push_cmd,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output kscan_pkg::kscan_cmd_t head_cmd
);
  import kscan_pkg::*;

  kscan_cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_cmd  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && not_empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/kscan_back.sv]
// ----------------------------------------------------------------------------
// kscan_back
// Holds the key ring and display direction, applies one command per tick
// and emits its eight digit writes through a registered output.
// ----------------------------------------------------------------------------
module kscan_back #(
  parameter int RING_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  input  kscan_pkg::kscan_cmd_t             cmd,
  output logic                              cmd_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kscan_pkg::DIGIT_W-1:0]     digit_position,
  output logic                              digit_blank,
  output logic [kscan_pkg::KEY_W-1:0]       digit_value,
  output logic [kscan_pkg::ROW_OUT_W-1:0]   next_row,
  output logic                              final_write
);
  import kscan_pkg::*;

  localparam int IW = $clog2(RING_DEPTH);

  typedef enum logic {IDLE, EMIT} state_t;

  state_t               state;
  logic [DIGIT_W-1:0]   cnt;
  logic [IW-1:0]        ring_pointer;
  logic [IW-1:0]        ring_pointer_next;
  logic [IW-1:0]        rd_idx;
  logic [IW-1:0]        rd_idx_next;
  logic                 direction_right;
  logic [ROW_OUT_W-1:0] row_hold;
  logic                 ring_blank [RING_DEPTH];
  logic [KEY_W-1:0]     ring_value [RING_DEPTH];

  logic load;
  logic last;

  assign load    = (state == EMIT) && (!out_valid || !out_stall);
  assign last    = (cnt == DIGIT_W'(DIGITS - 1));
  assign cmd_pop = cmd_valid && ((state == IDLE) || (load && last));

  // Ring index stepping with wrap
  always_comb begin
    rd_idx_next       = (rd_idx == IW'(RING_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
    ring_pointer_next = ring_pointer;
    if (cmd.wr) begin
      ring_pointer_next = (ring_pointer == IW'(RING_DEPTH - 1)) ? '0 :
                          ring_pointer + 1'b1;
    end
  end

  // Ring contents; blank flags reset, values only meaningful when not blank.
  // A key written in the same tick as a switch edge survives the blanking.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_blank[i] <= 1'b1;
      end
    end else if (cmd_pop) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        if (cmd.wr && (IW'(i) == ring_pointer)) begin
          ring_blank[i] <= 1'b0;
        end else if (cmd.flip) begin
          ring_blank[i] <= 1'b1;
        end
      end
      if (cmd.wr) begin
        ring_value[ring_pointer] <= cmd.key;
      end
    end
  end

  // Emit sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      cnt             <= '0;
      out_valid       <= 1'b0;
      ring_pointer    <= '0;
      rd_idx          <= '0;
      direction_right <= 1'b0;
      row_hold        <= '0;
    end else begin
      if (load) begin
        out_valid      <= 1'b1;
        digit_position <= direction_right ? cnt : DIGIT_W'(DIGITS - 1) - cnt;
        digit_blank    <= ring_blank[rd_idx];
        digit_value    <= ring_blank[rd_idx] ? '0 : ring_value[rd_idx];
        next_row       <= row_hold;
        final_write    <= last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      // New tick: update ring state, restart at the oldest entry
      if (cmd_pop) begin
        if (cmd.flip) begin
          direction_right <= !direction_right;
        end
        ring_pointer <= ring_pointer_next;
        rd_idx       <= ring_pointer_next;
        row_hold     <= cmd.next_row;
        cnt          <= '0;
        state        <= EMIT;
      end else if (load) begin
        cnt    <= cnt + 1'b1;
        rd_idx <= rd_idx_next;
        if (last) begin
          state <= IDLE;
        end
      end
    end
  end

endmodule

[rtl/keypad_scan_digit_queue.sv]
// ----------------------------------------------------------------------------
// keypad_scan_digit_queue
// Keypad matrix scanner feeding an eight-digit display queue.
//
// Input channel (in_valid/in_stall): one scan tick per transaction, carrying
// the direction switch level and the column bits of the driven row.
// Output channel (out_valid/out_stall): eight digit writes per tick, oldest
// ring entry first; final_write marks the eighth, next_row names the row to
// drive for the following tick.
// Path: an accepted tick is written into the command queue, popped into the
// display-side sequencer and handed out through the single output register,
// which hands out one digit write per cycle while out_stall is low.
// A two-entry command queue sits between the scanner front and the display
// side, so up to two further ticks are taken while writes are pending.
// When the receiver stalls, the held write stays put; once the queue fills,
// in_stall rises. Reset clears direction (left order), switch and row state,
// marks every row as having no key and blanks every ring entry at once.
// ----------------------------------------------------------------------------
module keypad_scan_digit_queue #(
  parameter int RING_DEPTH = 8,
  parameter int KEY_ROWS   = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            switch_pressed,
  input  logic [kscan_pkg::COL_W-1:0]     column_bits,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kscan_pkg::DIGIT_W-1:0]   digit_position,
  output logic                            digit_blank,
  output logic [kscan_pkg::KEY_W-1:0]     digit_value,
  output logic [kscan_pkg::ROW_OUT_W-1:0] next_row,
  output logic                            final_write
);
  import kscan_pkg::*;

  logic       cmd_push;
  logic       cmd_full;
  logic       cmd_pop;
  logic       cmd_ready;
  kscan_cmd_t front_cmd;
  kscan_cmd_t head_cmd;

  // Scanner front: switch edge, row tracking, key decode
  kscan_front #(
    .KEY_ROWS (KEY_ROWS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .switch_pressed (switch_pressed),
    .column_bits    (column_bits),
    .cmd_push       (cmd_push),
    .cmd_full       (cmd_full),
    .cmd            (front_cmd)
  );

  // Command queue
  kscan_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (front_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .not_empty (cmd_ready),
    .head_cmd  (head_cmd)
  );

  // Display side: ring, direction and digit writes
  kscan_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_ready),
    .cmd            (head_cmd),
    .cmd_pop        (cmd_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digit_position (digit_position),
    .digit_blank    (digit_blank),
    .digit_value    (digit_value),
    .next_row       (next_row),
    .final_write    (final_write)
  );

endmodule

[verif/keypad_scan_digit_queue_checker.sv]
// ----------------------------------------------------------------------------
// keypad_scan_digit_queue_checker
// Watches both channels of the keypad scanner. Every accepted scan tick runs
// through a local model of the scanner and the digit ring, which yields the
// eight digit writes that tick must produce. Accepted digit writes are
// compared field by field, in order, against those predictions.
// ----------------------------------------------------------------------------
module keypad_scan_digit_queue_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            switch_pressed,
  input  logic [kscan_pkg::COL_W-1:0]     column_bits,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [kscan_pkg::DIGIT_W-1:0]   digit_position,
  input  logic                            digit_blank,
  input  logic [kscan_pkg::KEY_W-1:0]     digit_value,
  input  logic [kscan_pkg::ROW_OUT_W-1:0] next_row,
  input  logic                            final_write,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import kscan_pkg::*;

  typedef struct packed {
    logic [DIGIT_W-1:0]   position;
    logic                 blank;
    logic [KEY_W-1:0]     value;
    logic [ROW_OUT_W-1:0] row;
    logic                 last;
  } digit_write_t;

  // Scanner model state
  logic                  dir_right;
  logic                  sw_held;
  logic [1:0]            scan_row;
  logic [LAST_KEY_W-1:0] last_key [4];
  logic                  ring_blank [8];
  logic [KEY_W-1:0]      ring_value [8];
  logic [2:0]            ring_ptr;

  digit_write_t writes_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic clear_model();
    dir_right = 1'b0;
    sw_held   = 1'b0;
    scan_row  = '0;
    ring_ptr  = '0;
    for (int r = 0; r < 4; r++) last_key[r] = NO_KEY;
    for (int e = 0; e < 8; e++) begin
      ring_blank[e] = 1'b1;
      ring_value[e] = '0;
    end
  endtask

  // Single-hot column code on the driven row -> key code, else no key
  function automatic logic [LAST_KEY_W-1:0] key_code(input logic [1:0] row,
                                                     input logic [COL_W-1:0] cols);
    logic [LAST_KEY_W-1:0] k;
    k = LAST_KEY_W'({row, 2'b00});
    case (cols)
      COL_KEY1: k = k + 8'd1;
      COL_KEY2: k = k + 8'd2;
      COL_KEY3: k = k + 8'd3;
      COL_KEY4: k = k + 8'd4;
      default:  return NO_KEY;
    endcase
    if (k == LAST_KEY_W'(KEY_WRAP)) k = '0;
    return k;
  endfunction

  // One scan tick: switch edge, key capture, row advance, eight digit writes
  task automatic scan_tick(input logic sw, input logic [COL_W-1:0] cols);
    logic [LAST_KEY_W-1:0] k;
    logic [1:0]            row;
    logic [2:0]            idx;
    digit_write_t          w;
    row = scan_row;
    if (sw) begin
      if (!sw_held) begin
        dir_right = !dir_right;
        for (int e = 0; e < 8; e++) begin
          ring_blank[e] = 1'b1;
          ring_value[e] = '0;
        end
        sw_held = 1'b1;
      end
    end else begin
      sw_held = 1'b0;
    end

    k = key_code(row, cols);
    if (k < LAST_KEY_W'(KEY_LIMIT)) begin
      if (k != last_key[row]) begin
        ring_blank[ring_ptr] = 1'b0;
        ring_value[ring_ptr] = k[KEY_W-1:0];
        ring_ptr             = ring_ptr + 3'd1;
        last_key[row]        = k;
      end
    end else begin
      last_key[row] = k;
    end

    scan_row = row + 2'd1;

    for (int i = 0; i < DIGITS; i++) begin
      idx        = ring_ptr + 3'(i);
      w.position = dir_right ? 3'(i) : 3'(DIGITS - 1 - i);
      w.blank    = ring_blank[idx];
      w.value    = ring_blank[idx] ? '0 : ring_value[idx];
      w.row      = scan_row;
      w.last     = (i == DIGITS - 1);
      writes_due.push_back(w);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare finished writes first, then predict from the accepted tick
  always @(posedge clk) begin : monitor
    digit_write_t want;
    if (rst) begin
      clear_model();
      writes_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (writes_due.size() == 0) begin
          $error("digit write with no transaction outstanding: position %0d value %0d",
                 digit_position, digit_value);
          fail_count++;
        end else begin
          want = writes_due.pop_front();
          check_field("digit_position", want.position, digit_position);
          check_field("digit_blank", want.blank, digit_blank);
          check_field("digit_value", want.value, digit_value);
          check_field("next_row", want.row, next_row);
          check_field("final_write", want.last, final_write);
        end
      end
      if (in_valid && !in_stall) scan_tick(switch_pressed, column_bits);
    end
    pending = writes_due.size();
  end

endmodule

[verif/keypad_scan_digit_queue_tb.sv]
// ----------------------------------------------------------------------------
// keypad_scan_digit_queue_tb
// Drives scan ticks into the keypad scanner: a directed sweep over every key,
// repeated keys, no-key codes and switch edges, then a long output hold-off
// that backs the block up, then random ticks in phases with no idling,
// sender gaps, receiver stalls and both. A checker instance does the scoring.
// ----------------------------------------------------------------------------
module keypad_scan_digit_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kscan_pkg::*;

  localparam int LONG_HOLD    = 80;
  localparam int PHASE_TICKS  = 50;
  localparam int SETTLE_CYC   = 20;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 switch_pressed;
  logic [COL_W-1:0]     column_bits;
  logic                 out_valid;
  logic                 out_stall;
  logic [DIGIT_W-1:0]   digit_position;
  logic                 digit_blank;
  logic [KEY_W-1:0]     digit_value;
  logic [ROW_OUT_W-1:0] next_row;
  logic                 final_write;

  int fail_count;
  int pending;
  int send_idle_pct;
  int stall_pct;
  bit long_hold;

  keypad_scan_digit_queue dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .switch_pressed (switch_pressed),
    .column_bits    (column_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digit_position (digit_position),
    .digit_blank    (digit_blank),
    .digit_value    (digit_value),
    .next_row       (next_row),
    .final_write    (final_write)
  );

  keypad_scan_digit_queue_checker digit_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .switch_pressed (switch_pressed),
    .column_bits    (column_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digit_position (digit_position),
    .digit_blank    (digit_blank),
    .digit_value    (digit_value),
    .next_row       (next_row),
    .final_write    (final_write),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Timeout guard
  initial begin
    #2000000;
    $display("keypad_scan_digit_queue_tb: errors");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        for (int c = 0; c < LONG_HOLD; c++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        long_hold = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // One scan tick transaction; returns at the falling edge after acceptance
  task automatic send_tick(input logic sw, input logic [COL_W-1:0] cols);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    switch_pressed <= sw;
    column_bits    <= cols;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender pause until every predicted digit write has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly single-key codes, the rest arbitrary column patterns
  function automatic logic [COL_W-1:0] rand_cols();
    if ($urandom_range(99) < 60) begin
      case ($urandom_range(3))
        0:       return COL_KEY1;
        1:       return COL_KEY2;
        2:       return COL_KEY3;
        default: return COL_KEY4;
      endcase
    end
    return COL_W'($urandom_range(255));
  endfunction

  initial begin
    logic             sw;
    logic [COL_W-1:0] sweep [4];
    int               idle_of [4];
    int               stall_of [4];

    sweep    = '{COL_KEY1, COL_KEY2, COL_KEY3, COL_KEY4};
    idle_of  = '{0, 56, 0, 16};
    stall_of = '{0, 0, 56, 16};

    rst            = 1'b1;
    in_valid       = 1'b0;
    switch_pressed = 1'b0;
    column_bits    = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    long_hold      = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every key on every row; row 3 with the last column wraps to key 0
    for (int k = 0; k < 16; k++) send_tick(1'b0, sweep[k / 4]);
    // Same key again on each row: nothing queued
    for (int k = 0; k < 4; k++) send_tick(1'b0, COL_KEY4);
    // No-key codes, with a held press, a release and a second press
    send_tick(1'b1, 8'h00);
    send_tick(1'b1, 8'hFF);
    send_tick(1'b0, 8'h0C);
    send_tick(1'b1, 8'h80);
    send_tick(1'b0, COL_KEY4);
    drain();

    // Long output hold-off while ticks keep coming: queue fills, input stalls
    long_hold = 1'b1;
    sw = 1'b0;
    for (int k = 0; k < 8; k++) send_tick(sw, rand_cols());
    drain();

    // Random phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_of[ph];
      stall_pct     = stall_of[ph];
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if ($urandom_range(99) < 15) sw = ~sw;
        send_tick(sw, rand_cols());
      end
      drain();
    end

    stall_pct = 0;
    repeat (SETTLE_CYC) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("keypad_scan_digit_queue_tb: clean");
    end else begin
      $display("keypad_scan_digit_queue_tb: errors");
    end
    $finish;
  end

endmodule
